@@ rtl/rgb_patch_rms_distance_top_macros.svh @@
// assertion macros for the rgb patch rms distance rtl
`ifndef RGB_PATCH_RMS_DISTANCE_TOP_MACROS_SVH
`define RGB_PATCH_RMS_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define RGBRMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define RGBRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rgbrms_pkg.sv @@
`timescale 1ns / 1ps

package rgbrms_pkg;

	// patch capacity in pixel pairs
	localparam int unsigned MAX_PIXELS = 4096;

	// channel, per-lane and merge widths
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned SQ_W    = 2 * CHAN_W;
	localparam int unsigned MERGE_W = SQ_W + 2;

	// largest squared channel difference summed over one patch
	localparam longint unsigned MAX_SQ = 64'(255) * 64'(255);
	localparam longint unsigned MAX_SQ_SUM = 64'(MAX_PIXELS) * 64'(3) * MAX_SQ;
	localparam int unsigned SUM_W = $clog2(MAX_SQ_SUM + 64'(1));

	// width of the pixels_used result
	localparam int unsigned TALLY_W = 13;

	// internal pixel count, wide enough to reach the capacity
	localparam int unsigned COUNT_W = $clog2(MAX_PIXELS + 1);

	// mean = (sum << FRAC_W) / (3 * count)
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned NUM_W  = SUM_W + FRAC_W;
	localparam int unsigned DEN_W  = $clog2(3 * MAX_PIXELS + 1);
	localparam int unsigned QUOT_W = 32;
	localparam int unsigned ROOT_W = QUOT_W / 2;
	localparam int unsigned RMS_W  = 16;

	// sequencer for the per-patch finish
	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIV,
		ST_SQRT,
		ST_PUSH
	} state_t;

endpackage

@@ rtl/rgb_patch_rms_distance_top.sv @@
`timescale 1ns / 1ps
// RMS channel difference of two RGB8 patches, streamed one pixel pair per request.
// Input channel: in_valid/in_ready with both pixels and last_pixel. The pair marked
// last is part of the patch and closes it. Output channel: out_valid/out_ready with
// rms_distance (floor of 256 times the RMS difference, unsigned Q8.8), pixels_used
// and overflowed (pairs past the 4096-pair capacity were dropped).
// Throughput: one pair per cycle while a patch streams in; three lanes square the
// channel differences and a merge adder folds them into the running sum.
// Finish: after the last pair is accepted, the result passes through the bit-serial
// divider, the digit-serial square root and the output register; in_ready stays low
// from the close of the patch until the result is in the output register, so intake
// pauses once per patch.
// Stall: the result waits in the output register while out_ready is low, and the
// next patch streams in meanwhile; its result waits on that slot, with in_ready low.
// Reset: arst_n clears the sum, count, overflow mark, sequencer and out_valid.
`include "rgb_patch_rms_distance_top_macros.svh"

module rgb_patch_rms_distance_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     first_red,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     first_green,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     first_blue,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     second_red,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     second_green,
	input  logic [rgbrms_pkg::CHAN_W-1:0]     second_blue,
	input  logic                              last_pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rgbrms_pkg::RMS_W-1:0]      rms_distance,
	output logic [rgbrms_pkg::TALLY_W-1:0]    pixels_used,
	output logic                              overflowed
);

	localparam int unsigned SUM_W   = rgbrms_pkg::SUM_W;
	localparam int unsigned TALLY_W = rgbrms_pkg::TALLY_W;
	localparam int unsigned COUNT_W = rgbrms_pkg::COUNT_W;
	localparam int unsigned MERGE_W = rgbrms_pkg::MERGE_W;
	localparam int unsigned DEN_W   = rgbrms_pkg::DEN_W;

	rgbrms_pkg::state_t state_q, state_nxt;

	logic                         accept;
	logic                         room;
	logic                         valid_s1;
	logic                         last_s1;
	logic                         use_s1;
	logic                         close_s1;
	logic [COUNT_W-1:0]           tally_q;
	logic                         flag_q;
	logic [SUM_W-1:0]             sum_q;
	logic [SUM_W-1:0]             sum_nxt;
	logic [MERGE_W-1:0]           merged;
	logic [rgbrms_pkg::SQ_W-1:0]  sq_r_s1;
	logic [rgbrms_pkg::SQ_W-1:0]  sq_g_s1;
	logic [rgbrms_pkg::SQ_W-1:0]  sq_b_s1;
	logic [COUNT_W-1:0]           res_count_q;
	logic                         res_flag_q;
	logic [DEN_W-1:0]             denom;
	logic                         div_done;
	logic [rgbrms_pkg::QUOT_W-1:0] quot;
	logic                         sqrt_start;
	logic                         sqrt_done;
	logic [rgbrms_pkg::ROOT_W-1:0] root;
	logic                         push;
	logic                         slot_free;
	logic                         out_valid_q;
	logic [rgbrms_pkg::RMS_W-1:0] rms_q;
	logic [TALLY_W-1:0]           used_q;
	logic                         ovf_q;

	assign accept    = in_valid && in_ready;
	assign room      = (tally_q != COUNT_W'(rgbrms_pkg::MAX_PIXELS));
	assign close_s1  = valid_s1 && last_s1;
	assign slot_free = !out_valid_q || out_ready;

	// one lane per color channel
	rgbrms_lane u_lane_r (
		.clk    (clk),
		.en     (accept),
		.chan_a (first_red),
		.chan_b (second_red),
		.sq_s1  (sq_r_s1)
	);

	rgbrms_lane u_lane_g (
		.clk    (clk),
		.en     (accept),
		.chan_a (first_green),
		.chan_b (second_green),
		.sq_s1  (sq_g_s1)
	);

	rgbrms_lane u_lane_b (
		.clk    (clk),
		.en     (accept),
		.chan_a (first_blue),
		.chan_b (second_blue),
		.sq_s1  (sq_b_s1)
	);

	// merge the lanes into the running sum
	assign merged  = MERGE_W'(sq_r_s1) + MERGE_W'(sq_g_s1) + MERGE_W'(sq_b_s1);
	assign sum_nxt = sum_q + ((valid_s1 && use_s1) ? SUM_W'(merged) : SUM_W'(0));

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			use_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				last_s1 <= last_pixel;
				use_s1  <= room;
			end
		end
	end

	// count, overflow mark and sum; cleared when a patch closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			flag_q  <= 1'b0;
			sum_q   <= '0;
		end else if (close_s1) begin
			tally_q <= '0;
			flag_q  <= 1'b0;
			sum_q   <= '0;
		end else begin
			sum_q <= sum_nxt;
			if (accept) begin
				if (room) begin
					tally_q <= tally_q + COUNT_W'(1);
				end else begin
					flag_q <= 1'b1;
				end
			end
		end
	end

	// patch totals held for the result
	always_ff @(posedge clk) begin
		if (close_s1) begin
			res_count_q <= tally_q;
			res_flag_q  <= flag_q;
		end
	end

	// divisor 3 * count
	assign denom = DEN_W'(tally_q) + DEN_W'({tally_q, 1'b0});

	rgbrms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (close_s1),
		.numer  ({sum_nxt, rgbrms_pkg::FRAC_W'(0)}),
		.denom  (denom),
		.done   (div_done),
		.quot   (quot)
	);

	rgbrms_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (quot),
		.done     (sqrt_done),
		.root     (root)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbrms_pkg::ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rgbrms_pkg::ST_ACCUM: begin
				if (close_s1) state_nxt = rgbrms_pkg::ST_DIV;
			end
			rgbrms_pkg::ST_DIV: begin
				if (div_done) state_nxt = rgbrms_pkg::ST_SQRT;
			end
			rgbrms_pkg::ST_SQRT: begin
				if (sqrt_done) state_nxt = rgbrms_pkg::ST_PUSH;
			end
			rgbrms_pkg::ST_PUSH: begin
				if (slot_free) state_nxt = rgbrms_pkg::ST_ACCUM;
			end
			default: state_nxt = rgbrms_pkg::ST_ACCUM;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		sqrt_start = 1'b0;
		push       = 1'b0;
		unique case (state_q)
			rgbrms_pkg::ST_ACCUM: in_ready = !close_s1;
			rgbrms_pkg::ST_DIV:   sqrt_start = div_done;
			rgbrms_pkg::ST_SQRT:  ;
			rgbrms_pkg::ST_PUSH:  push = slot_free;
			default:              ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rms_q  <= root;
			used_q <= TALLY_W'(res_count_q);
			ovf_q  <= res_flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign rms_distance = rms_q;
	assign pixels_used  = used_q;
	assign overflowed   = ovf_q;

	// checks
	`RGBRMS_ASSERT_NOW(a_tally_cap, clk, arst_n, 1'b1,
		tally_q <= COUNT_W'(rgbrms_pkg::MAX_PIXELS), "pixel count beyond capacity")
	`RGBRMS_ASSERT_NEXT(a_close_clears, clk, arst_n, close_s1,
		tally_q == '0 && sum_q == '0 && !flag_q, "patch state not cleared after close")
	`RGBRMS_ASSERT_NOW(a_push_count, clk, arst_n, state_q == rgbrms_pkg::ST_PUSH,
		res_count_q != '0, "result with empty pixel count")

endmodule

@@ rtl/rgbrms_lane.sv @@
`timescale 1ns / 1ps

module rgbrms_lane (
	input  logic                             clk,
	input  logic                             en,
	input  logic [rgbrms_pkg::CHAN_W-1:0]    chan_a,
	input  logic [rgbrms_pkg::CHAN_W-1:0]    chan_b,
	output logic [rgbrms_pkg::SQ_W-1:0]      sq_s1
);

	logic [rgbrms_pkg::CHAN_W-1:0] diff;

	// absolute channel difference
	assign diff = (chan_a > chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);

	// registered square
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= rgbrms_pkg::SQ_W'(diff) * rgbrms_pkg::SQ_W'(diff);
		end
	end

endmodule

@@ rtl/rgbrms_div.sv @@
`timescale 1ns / 1ps

module rgbrms_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rgbrms_pkg::NUM_W-1:0]     numer,
	input  logic [rgbrms_pkg::DEN_W-1:0]     denom,
	output logic                             done,
	output logic [rgbrms_pkg::QUOT_W-1:0]    quot
);

	localparam int unsigned NUM_W = rgbrms_pkg::NUM_W;
	localparam int unsigned DEN_W = rgbrms_pkg::DEN_W;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   den_ext;
	logic             ge;

	// one restoring step: bring down the next numerator bit
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign den_ext = {1'b0, den_q};
	assign ge      = (trial >= den_ext);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the numerator
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - den_ext) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q[rgbrms_pkg::QUOT_W-1:0];

endmodule

@@ rtl/rgbrms_sqrt.sv @@
`timescale 1ns / 1ps

module rgbrms_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rgbrms_pkg::QUOT_W-1:0]    radicand,
	output logic                             done,
	output logic [rgbrms_pkg::ROOT_W-1:0]    root
);

	localparam int unsigned IN_W   = rgbrms_pkg::QUOT_W;
	localparam int unsigned ROOT_W = rgbrms_pkg::ROOT_W;
	localparam int unsigned REM_W  = ROOT_W + 1;
	localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

	logic [IN_W-1:0]    val_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+1:0]   trial;
	logic               ge;

	// one digit step: next two radicand bits against 4*root+1
	assign rem_sh = {rem_q, val_q[IN_W-1 -: 2]};
	assign trial  = (REM_W + 2)'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and root update
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[IN_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ tb/sv/tb_rgb_patch_rms_distance_top.sv @@
`timescale 1ns / 1ps

module tb_rgb_patch_rms_distance_top;

	localparam int unsigned CHAN_W     = rgbrms_pkg::CHAN_W;
	localparam int unsigned RMS_W      = rgbrms_pkg::RMS_W;
	localparam int unsigned TALLY_W    = rgbrms_pkg::TALLY_W;
	localparam int unsigned FRAC_W     = rgbrms_pkg::FRAC_W;
	localparam int unsigned MAX_PIXELS = rgbrms_pkg::MAX_PIXELS;

	// one expected patch result
	typedef struct packed {
		logic [RMS_W-1:0]   rms;
		logic [TALLY_W-1:0] used;
		logic               ovf;
	} patch_result_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [CHAN_W-1:0]   first_red    = '0;
	logic [CHAN_W-1:0]   first_green  = '0;
	logic [CHAN_W-1:0]   first_blue   = '0;
	logic [CHAN_W-1:0]   second_red   = '0;
	logic [CHAN_W-1:0]   second_green = '0;
	logic [CHAN_W-1:0]   second_blue  = '0;
	logic                last_pixel   = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [RMS_W-1:0]    rms_distance;
	logic [TALLY_W-1:0]  pixels_used;
	logic                overflowed;

	// running patch state of the predictor
	longint unsigned     patch_sq_sum;
	int unsigned         patch_count;
	logic                patch_dropped;

	patch_result_t       pending_results[$];
	int                  error_count    = 0;
	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;

	rgb_patch_rms_distance_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.last_pixel   (last_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rms_distance (rms_distance),
		.pixels_used  (pixels_used),
		.overflowed   (overflowed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("rgb_patch_rms_distance_top: mismatch");
		$finish;
	end

	// floor square root, argument below 2^36
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		for (int b = 17; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root;
	endfunction

	function automatic int unsigned chan_sq(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		int unsigned d;
		d = (a > b) ? (a - b) : (b - a);
		return d * d;
	endfunction

	// fold one accepted request into the predicted patch state
	function automatic void predict_pair(
		input logic [CHAN_W-1:0] fr, input logic [CHAN_W-1:0] fg, input logic [CHAN_W-1:0] fb,
		input logic [CHAN_W-1:0] sr, input logic [CHAN_W-1:0] sg, input logic [CHAN_W-1:0] sb,
		input logic last);
		patch_result_t   res;
		longint unsigned mean;
		longint unsigned root;
		if (patch_count < MAX_PIXELS) begin
			patch_sq_sum += chan_sq(fr, sr) + chan_sq(fg, sg) + chan_sq(fb, sb);
			patch_count++;
		end else begin
			patch_dropped = 1'b1;
		end
		if (last) begin
			mean = (patch_sq_sum << FRAC_W) / (64'd3 * patch_count);
			root = floor_sqrt(mean);
			if (root > 64'hFFFF)
				root = 64'hFFFF;
			res.rms  = root[RMS_W-1:0];
			res.used = patch_count[TALLY_W-1:0];
			res.ovf  = patch_dropped;
			pending_results.insert(pending_results.size(), res);
			patch_sq_sum  = 0;
			patch_count   = 0;
			patch_dropped = 1'b0;
		end
	endfunction

	// drive one request and wait until it is taken
	task automatic send_pair(
		input logic [CHAN_W-1:0] fr, input logic [CHAN_W-1:0] fg, input logic [CHAN_W-1:0] fb,
		input logic [CHAN_W-1:0] sr, input logic [CHAN_W-1:0] sg, input logic [CHAN_W-1:0] sb,
		input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		first_red    <= fr;
		first_green  <= fg;
		first_blue   <= fb;
		second_red   <= sr;
		second_green <= sg;
		second_blue  <= sb;
		last_pixel   <= last;
		do
			@(posedge clk);
		while (!in_ready);
		predict_pair(fr, fg, fb, sr, sg, sb, last);
	endtask

	// one channel value pair in a random style
	task automatic pick_chan_pair(output logic [CHAN_W-1:0] a, output logic [CHAN_W-1:0] b);
		int style;
		style = $urandom_range(0, 9);
		a = CHAN_W'($urandom);
		if (style < 5) begin
			b = CHAN_W'($urandom);
		end else if (style < 7) begin
			a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else begin
			// small difference around the first value
			b = a + 8'($urandom_range(0, 6)) - 8'd3;
		end
	endtask

	task automatic send_random_patch(input int n);
		logic [CHAN_W-1:0] fr, fg, fb, sr, sg, sb;
		for (int i = 0; i < n; i++) begin
			pick_chan_pair(fr, sr);
			pick_chan_pair(fg, sg);
			pick_chan_pair(fb, sb);
			send_pair(fr, fg, fb, sr, sg, sb, i == n - 1);
		end
	endtask

	// corner values: zero and full-scale differences, single channels, short patches
	task automatic test_extremes();
		send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
		send_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1);
		send_pair(8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1);
		send_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
		send_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
		send_pair(8'h10, 8'h90, 8'h37, 8'hC8, 8'h10, 8'h00, 1'b1);
	endtask

	// random patches, mostly short
	task automatic test_random_patches(input int items);
		int sent;
		int sel;
		int n;
		sent = 0;
		while (sent < items) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				n = $urandom_range(1, 8);
			else if (sel < 9)
				n = $urandom_range(9, 32);
			else
				n = $urandom_range(33, 100);
			send_random_patch(n);
			sent += n;
		end
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		patch_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result rms_distance %0d pixels_used %0d overflowed %0d",
					$time, rms_distance, pixels_used, overflowed);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rms_distance !== want.rms) begin
					$display("%0t rms_distance expected %0d actual %0d",
						$time, want.rms, rms_distance);
					error_count++;
				end
				if (pixels_used !== want.used) begin
					$display("%0t pixels_used expected %0d actual %0d",
						$time, want.used, pixels_used);
					error_count++;
				end
				if (overflowed !== want.ovf) begin
					$display("%0t overflowed expected %0d actual %0d",
						$time, want.ovf, overflowed);
					error_count++;
				end
			end
		end
	end

	// test sequence
	initial begin
		int wait_cycles;
		patch_sq_sum  = 0;
		patch_count   = 0;
		patch_dropped = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no idling
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_extremes();
		test_random_patches(150);

		// sender mostly idle
		send_idle_pct  = 82;
		recv_stall_pct = 0;
		test_random_patches(150);

		// receiver mostly stalled
		send_idle_pct  = 0;
		recv_stall_pct = 82;
		test_extremes();
		test_random_patches(150);

		// both sides idling now and then
		send_idle_pct  = 25;
		recv_stall_pct = 25;
		test_random_patches(150);

		in_valid <= 1'b0;

		// drain outstanding results
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 200_000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_results.size() != 0) begin
			$display("rgb_patch_rms_distance_top: mismatch");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			if (error_count == 0)
				$display("rgb_patch_rms_distance_top: match");
			else
				$display("rgb_patch_rms_distance_top: mismatch");
			$finish;
		end
	end

endmodule
